[hdl/tbp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_pkg: shared definitions of the tournament branch predictor
// Widths, counter reset codes and the saturating counter step.
// ----------------------------------------------------------------------------
package tbp_pkg;

  // Default table index width (2048 entries) and global history length.
  localparam int unsigned TBP_TABLE_IDX_W = 11;
  localparam int unsigned TBP_HIST_W      = 11;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned TBP_PC_W     = 32;
  localparam int unsigned TBP_TALLY_W  = 32;
  localparam int unsigned TBP_IN_W     = 40;
  localparam int unsigned TBP_OUT_W    = 72;

  // Bit positions inside the output tdata.
  localparam int unsigned TBP_OUT_PRED_BIT   = 0;
  localparam int unsigned TBP_OUT_RIGHT_BIT  = 1;
  localparam int unsigned TBP_OUT_BIM_BIT    = 2;
  localparam int unsigned TBP_OUT_HIT_LSB    = 3;
  localparam int unsigned TBP_OUT_BRANCH_LSB = 35;

  typedef logic [1:0] ctr_t;

  // Counter codes after reset.
  localparam ctr_t CTR_STRONG_TAKEN = 2'd3;
  localparam ctr_t CTR_STRONG_GSHARE = 2'd0;
  localparam ctr_t CTR_MAX = 2'd3;
  localparam ctr_t CTR_MIN = 2'd0;

  // Two-bit saturating counter step.
  function automatic ctr_t sat_step(input ctr_t c, input logic up);
    ctr_t r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    end
    return r;
  endfunction

endpackage

[hdl/tbp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_ram: generic single-write, single-read RAM
// One write port and one registered read port; a read of the address being
// written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module tbp_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/tournament_branch_predictor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tournament_branch_predictor: bimodal and gshare predictors with a chooser
// Takes resolved branches and reports the chosen prediction, its accuracy
// and running tallies, while training all three counter tables.
// ----------------------------------------------------------------------------
// The block takes one resolved branch request per clock while the output
// side is not stalled and returns one result request for each, in order,
// once it has passed the stage 1 registers and the output register. The
// sustained rate of one branch per clock is set by the table RAMs: each
// table is read once when a branch is taken in and written once when it
// leaves stage 1, and a bypass register covers a branch that hits the entry
// its predecessor is writing. After reset the block runs a clearing pass
// that writes the reset codes into every table entry, one entry per clock;
// s_axis_tready stays low until it is done. The tables hold 2**TableIdxW
// entries (2048 with the default size) and only the low TableIdxW bits of
// the branch address index them.
// ----------------------------------------------------------------------------
module tournament_branch_predictor #(
  parameter int unsigned TableIdxW = tbp_pkg::TBP_TABLE_IDX_W,  // 4 to 16
  parameter int unsigned HistW     = tbp_pkg::TBP_HIST_W         // 1 to 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Branch requests.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [31:0] branch_pc, [32] taken, [39:33] zero
  input  logic [tbp_pkg::TBP_IN_W-1:0]   s_axis_tdata,
  // Result requests.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] predicted_taken, [1] prediction_right, [2] used_bimodal,
  // [34:3] hit_count, [66:35] branch_count, [71:67] zero
  output logic [tbp_pkg::TBP_OUT_W-1:0]  m_axis_tdata
);

  import tbp_pkg::*;

  localparam int unsigned Depth = 1 << TableIdxW;
  localparam int unsigned MixW  = (HistW > TableIdxW) ? HistW : TableIdxW;

  typedef logic [TableIdxW-1:0] idx_t;

  // --------------------------------------------------------------------------
  // Clearing pass after reset.
  // --------------------------------------------------------------------------
  logic clearing_q, clearing_d;
  idx_t clr_idx_q, clr_idx_d;

  always_comb begin
    clearing_d = clearing_q;
    clr_idx_d  = clr_idx_q;
    if (clearing_q) begin
      clr_idx_d = clr_idx_q + idx_t'(1);
      if (clr_idx_q == idx_t'(Depth - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_idx_q  <= clr_idx_d;
    end
  end

  // --------------------------------------------------------------------------
  // Input side: index computation and table reads.
  // --------------------------------------------------------------------------
  logic             in_fire;
  logic             s1_valid_q, s1_valid_d;
  logic             s1_fire;
  logic             s1_adv;
  logic [HistW-1:0] hist_q, hist_d;
  idx_t             in_a, in_g;
  logic             in_taken;
  logic [MixW-1:0]  mix;

  assign in_taken = s_axis_tdata[TBP_PC_W];
  assign in_a     = s_axis_tdata[TableIdxW-1:0];
  assign mix      = MixW'(hist_q) ^ MixW'(in_a);
  assign in_g     = mix[TableIdxW-1:0];

  // Stage 1 moves on when the output register is free or being emptied.
  assign s1_adv        = !m_axis_tvalid || m_axis_tready;
  assign s1_fire       = s1_valid_q && s1_adv;
  assign s_axis_tready = !clearing_q && (!s1_valid_q || s1_adv);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // The history depends only on outcomes, so it is shifted as soon as a
  // branch is taken in; the gshare index above uses the value before it.
  always_comb begin
    hist_d = hist_q;
    if (in_fire) begin
      hist_d = (hist_q << 1) | HistW'(in_taken);
    end
  end

  // --------------------------------------------------------------------------
  // Tables. Bimodal and chooser share their index and sit in one RAM as
  // {chooser, bimodal}; gshare has a RAM of its own.
  // --------------------------------------------------------------------------
  logic       bc_we, g_we;
  idx_t       bc_waddr, g_waddr;
  logic [3:0] bc_wdata, bc_rdata;
  ctr_t       g_wdata, g_rdata;

  idx_t       s1_a_q, s1_g_q;
  logic       s1_taken_q;
  logic       fwd_bc_hit_q;
  logic       fwd_g_hit_q;
  logic [3:0] fwd_bc_q;
  ctr_t       fwd_g_q;

  ctr_t       bim_cur, cho_cur, gsh_cur;
  ctr_t       bim_new, cho_new, gsh_new;
  logic       bim_pred, gsh_pred, use_bim, pred, right;

  always_comb begin
    if (clearing_q) begin
      bc_we    = 1'b1;
      bc_waddr = clr_idx_q;
      bc_wdata = {CTR_STRONG_GSHARE, CTR_STRONG_TAKEN};
      g_we     = 1'b1;
      g_waddr  = clr_idx_q;
      g_wdata  = CTR_STRONG_TAKEN;
    end else begin
      bc_we    = s1_fire;
      bc_waddr = s1_a_q;
      bc_wdata = {cho_new, bim_new};
      g_we     = s1_fire;
      g_waddr  = s1_g_q;
      g_wdata  = gsh_new;
    end
  end

  tbp_ram #(
    .Width (4),
    .Depth (Depth)
  ) u_bc_ram (
    .clk_i     (clk_i),
    .wr_en_i   (bc_we),
    .wr_addr_i (bc_waddr),
    .wr_data_i (bc_wdata),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_a),
    .rd_data_o (bc_rdata)
  );

  tbp_ram #(
    .Width ($bits(ctr_t)),
    .Depth (Depth)
  ) u_gshare_ram (
    .clk_i     (clk_i),
    .wr_en_i   (g_we),
    .wr_addr_i (g_waddr),
    .wr_data_i (g_wdata),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_g),
    .rd_data_o (g_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage 1: predict, train and form the result.
  // --------------------------------------------------------------------------
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  // The RAM read returns the old entry when the branch ahead writes the same
  // entry on the same edge, so that write is caught here and used instead.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_a_q       <= in_a;
      s1_g_q       <= in_g;
      s1_taken_q   <= in_taken;
      fwd_bc_hit_q <= s1_fire && (s1_a_q == in_a);
      fwd_g_hit_q  <= s1_fire && (s1_g_q == in_g);
      fwd_bc_q     <= {cho_new, bim_new};
      fwd_g_q      <= gsh_new;
    end
  end

  always_comb begin
    bim_cur  = fwd_bc_hit_q ? fwd_bc_q[1:0] : bc_rdata[1:0];
    cho_cur  = fwd_bc_hit_q ? fwd_bc_q[3:2] : bc_rdata[3:2];
    gsh_cur  = fwd_g_hit_q ? fwd_g_q : g_rdata;

    // A counter above one predicts taken, or picks bimodal for the chooser.
    bim_pred = bim_cur[1];
    gsh_pred = gsh_cur[1];
    use_bim  = cho_cur[1];
    pred     = use_bim ? bim_pred : gsh_pred;
    right    = (pred == s1_taken_q);

    bim_new  = sat_step(bim_cur, s1_taken_q);
    gsh_new  = sat_step(gsh_cur, s1_taken_q);
    // The chooser only learns when exactly one predictor was right.
    cho_new  = (bim_pred != gsh_pred) ? sat_step(cho_cur, bim_pred == s1_taken_q)
                                      : cho_cur;
  end

  // --------------------------------------------------------------------------
  // Output register and tallies.
  // --------------------------------------------------------------------------
  logic                   out_valid_q, out_valid_d;
  logic                   out_pred_q, out_right_q, out_bim_q;
  logic [TBP_TALLY_W-1:0] hit_q, hit_d;
  logic [TBP_TALLY_W-1:0] branch_q, branch_d;

  always_comb begin
    out_valid_d = out_valid_q;
    hit_d       = hit_q;
    branch_d    = branch_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
      hit_d       = hit_q + TBP_TALLY_W'(right);
      branch_d    = branch_q + TBP_TALLY_W'(1);
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hit_q       <= '0;
      branch_q    <= '0;
    end else begin
      hist_q      <= hist_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      branch_q    <= branch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_pred_q  <= pred;
      out_right_q <= right;
      out_bim_q   <= use_bim;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[TBP_OUT_PRED_BIT]  = out_pred_q;
    m_axis_tdata[TBP_OUT_RIGHT_BIT] = out_right_q;
    m_axis_tdata[TBP_OUT_BIM_BIT]   = out_bim_q;
    m_axis_tdata[TBP_OUT_HIT_LSB +: TBP_TALLY_W]    = hit_q;
    m_axis_tdata[TBP_OUT_BRANCH_LSB +: TBP_TALLY_W] = branch_q;
  end

endmodule

[hdl/tbp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_checker: port-level assertions for the tournament branch predictor
// Checks occupancy, tally progress and stall behavior seen at the ports.
// ----------------------------------------------------------------------------
module tbp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tbp_pkg::TBP_OUT_W-1:0] m_axis_tdata
);

  import tbp_pkg::*;

  logic                   in_acc, out_acc;
  logic [1:0]             occ_q;
  logic                   seen_q;
  logic [TBP_TALLY_W-1:0] last_hit_q, last_branch_q;
  logic [TBP_TALLY_W-1:0] cur_hit, cur_branch;

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign out_acc    = m_axis_tvalid && m_axis_tready;
  assign cur_hit    = m_axis_tdata[TBP_OUT_HIT_LSB +: TBP_TALLY_W];
  assign cur_branch = m_axis_tdata[TBP_OUT_BRANCH_LSB +: TBP_TALLY_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      occ_q <= occ_q + 2'(in_acc) - 2'(out_acc);
      if (out_acc) begin
        seen_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_acc) begin
      last_hit_q    <= cur_hit;
      last_branch_q <= cur_branch;
    end
  end

  // A result is shown only for a branch that was taken in and not answered.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (occ_q != 2'd0))
    else $error("result shown with no branch outstanding");

  // At most two branches are held inside the block.
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (occ_q != 2'd2) || out_acc)
    else $error("branch taken in beyond the block's capacity");

  // Each result counts one more branch than the one before it.
  a_branch_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q |-> cur_branch == last_branch_q + TBP_TALLY_W'(1))
    else $error("branch tally did not advance by one");

  // The hit tally advances exactly when the prediction was right.
  a_hit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q |->
      cur_hit == last_hit_q + TBP_TALLY_W'(m_axis_tdata[TBP_OUT_RIGHT_BIT]))
    else $error("hit tally does not match prediction_right");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
